### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on the rising edge of clk, off while rst_n is low.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tcep_pkg.sv
`default_nettype none

package tcep_pkg;

  localparam int MAX_ARGS   = 8;
  localparam int ARG_IDX_W  = $clog2(MAX_ARGS);
  localparam int ARG_W      = 16;
  localparam int COLS_W     = 13;
  localparam int RES_MAX    = 3;
  localparam int RES_CNT_W  = 2;

  localparam logic [COLS_W-1:0] COLUMNS_RST   = 13'd80;
  localparam logic [3:0]        COLOR_DEFAULT = 4'd8;

  // Console bytes
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DIGIT0   = 8'h30;
  localparam logic [7:0] CH_DIGIT9   = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] GLYPH_BLINK = 8'd127;

  // Sequence final letters
  localparam logic [7:0] FIN_UP      = 8'h41;
  localparam logic [7:0] FIN_DOWN    = 8'h42;
  localparam logic [7:0] FIN_LEFT    = 8'h43;
  localparam logic [7:0] FIN_RIGHT   = 8'h44;
  localparam logic [7:0] FIN_COL     = 8'h45;
  localparam logic [7:0] FIN_ROW     = 8'h46;
  localparam logic [7:0] FIN_HIDE    = 8'h47;
  localparam logic [7:0] FIN_HOME    = 8'h48;
  localparam logic [7:0] FIN_CLEAR_I = 8'h49;
  localparam logic [7:0] FIN_CLEAR_J = 8'h4A;
  localparam logic [7:0] FIN_FG      = 8'h4D;
  localparam logic [7:0] FIN_BG      = 8'h4E;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_DONE  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PM_GROUND = 3'b001,
    PM_ESC    = 3'b010,
    PM_ARGS   = 3'b100
  } parse_mode_t;

  typedef struct packed {
    logic       func;
    logic [7:0] char_byte;
    logic       last_of_write;
  } item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  glyph;
    logic [15:0] col;
    logic [15:0] row;
    logic [3:0]  fg_code;
    logic [3:0]  bg_code;
    logic        cursor_hidden;
    logic [15:0] bytes_done;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]        cnt;
    result_t [RES_MAX-1:0]       res;
  } res_set_t;

  typedef struct packed {
    parse_mode_t                   mode;
    logic [MAX_ARGS-1:0][ARG_W-1:0] args;
    logic [ARG_IDX_W-1:0]          arg_idx;
    logic [15:0]                   cursor_x;
    logic [15:0]                   cursor_y;
    logic [3:0]                    fg;
    logic [3:0]                    bg;
    logic                          hide;
    logic                          blink;
    logic                          stopped;
    logic [15:0]                   byte_count;
  } cons_state_t;

endpackage

`default_nettype wire

### src/tcep_step.sv
`default_nettype none

module tcep_step (
  input  tcep_pkg::item_t                  item,
  input  tcep_pkg::cons_state_t            st,
  input  logic [tcep_pkg::COLS_W-1:0]      columns,
  output tcep_pkg::cons_state_t            st_nxt,
  output tcep_pkg::res_set_t               set
);
  import tcep_pkg::*;

  localparam logic [ARG_IDX_W-1:0] LAST_ARG = ARG_IDX_W'(MAX_ARGS - 1);

  logic [7:0]           b;
  logic [ARG_IDX_W-1:0] k;
  logic [ARG_W-1:0]     a0;
  logic [ARG_W-1:0]     a1;
  logic [ARG_W+3:0]     acc;
  logic [15:0]          x1;
  logic                 plain;
  result_t              b0;
  result_t              b1;
  logic [RES_CNT_W-1:0] nb;
  logic [RES_CNT_W-1:0] cnt;

  function automatic result_t mk(input logic [1:0] op, input logic [7:0] g,
                                 input logic [15:0] x, input logic [15:0] y,
                                 input logic [3:0] fg, input logic [3:0] bg,
                                 input logic hid, input logic [15:0] bytes);
    result_t r;
    r.op            = op;
    r.glyph         = g;
    r.col           = x;
    r.row           = y;
    r.fg_code       = fg;
    r.bg_code       = bg;
    r.cursor_hidden = hid;
    r.bytes_done    = bytes;
    r.last          = 1'b0;
    return r;
  endfunction

  assign b   = item.char_byte;
  assign k   = st.arg_idx;
  assign a0  = st.args[0];
  assign a1  = st.args[1];
  assign acc = ({4'b0, st.args[k]} << 3) + ({4'b0, st.args[k]} << 1)
             + {16'b0, b[3:0]};
  assign x1  = st.cursor_x + 16'd1;

  always_comb begin
    st_nxt = st;
    b0     = '0;
    b1     = '0;
    nb     = '0;
    plain  = 1'b0;
    set    = '0;
    cnt    = '0;

    if (item.func) begin
      // blink tick: toggle and draw at the cursor, nothing else moves
      st_nxt.blink = ~st.blink;
      b0 = mk(OP_DRAW, st.blink ? CH_SPACE : GLYPH_BLINK, st.cursor_x, st.cursor_y,
              st.fg, st.bg, st.hide, 16'd0);
      nb = 2'd1;
    end else if (!st.stopped) begin
      if (b == CH_NUL) begin
        st_nxt.stopped = 1'b1;
        st_nxt.mode    = PM_GROUND;
      end else begin
        if (st.byte_count != 16'hFFFF) begin
          st_nxt.byte_count = st.byte_count + 16'd1;
        end
        case (st.mode)
          PM_ESC: begin
            if (b == CH_LBRACKET) begin
              st_nxt.mode    = PM_ARGS;
              st_nxt.args    = '0;
              st_nxt.arg_idx = '0;
            end else begin
              st_nxt.mode = PM_GROUND;
              plain       = 1'b1;
            end
          end
          PM_ARGS: begin
            case (b) inside
              [CH_DIGIT0:CH_DIGIT9]: begin
                st_nxt.args[k] = (acc > 20'hFFFF) ? 16'hFFFF : acc[15:0];
              end
              CH_SEMI: begin
                // past the last slot, keep accumulating into it
                if (k != LAST_ARG) begin
                  st_nxt.arg_idx = k + ARG_IDX_W'(1);
                end
              end
              default: begin
                st_nxt.mode = PM_GROUND;
                case (b)
                  FIN_UP:    st_nxt.cursor_y = st.cursor_y - a0;
                  FIN_DOWN:  st_nxt.cursor_y = st.cursor_y + a0;
                  FIN_LEFT:  st_nxt.cursor_x = st.cursor_x - a0;
                  FIN_RIGHT: st_nxt.cursor_x = st.cursor_x + a0;
                  FIN_COL:   st_nxt.cursor_x = a0;
                  FIN_ROW:   st_nxt.cursor_y = a0;
                  FIN_HIDE:  st_nxt.hide     = (a0 == 16'd0);
                  FIN_HOME: begin
                    st_nxt.cursor_x = a0;
                    st_nxt.cursor_y = a1;
                  end
                  FIN_CLEAR_I, FIN_CLEAR_J: begin
                    b0 = mk(OP_CLEAR, 8'd0, st.cursor_x, st.cursor_y,
                            st.fg, st.bg, st.hide, 16'd0);
                    nb = 2'd1;
                  end
                  FIN_FG: if (a0 <= 16'd8) st_nxt.fg = a0[3:0];
                  FIN_BG: if (a0 <= 16'd8) st_nxt.bg = a0[3:0];
                  default: ;
                endcase
              end
            endcase
          end
          default: begin
            st_nxt.mode = PM_GROUND;
            plain       = 1'b1;
          end
        endcase

        if (plain) begin
          b0 = mk(OP_DRAW, CH_SPACE, st.cursor_x, st.cursor_y,
                  st.fg, st.bg, st.hide, 16'd0);
          case (b)
            CH_NL: begin
              nb              = 2'd1;
              st_nxt.cursor_y = st.cursor_y + 16'd1;
              st_nxt.cursor_x = 16'd0;
            end
            CH_BS: begin
              nb = 2'd2;
              if (st.cursor_x == 16'd0) begin
                st_nxt.cursor_x = 16'(columns) - 16'd1;
                st_nxt.cursor_y = st.cursor_y - 16'd1;
              end else begin
                st_nxt.cursor_x = st.cursor_x - 16'd1;
              end
              b1 = mk(OP_DRAW, CH_SPACE, st_nxt.cursor_x, st_nxt.cursor_y,
                      st.fg, st.bg, st.hide, 16'd0);
            end
            CH_ESC: begin
              st_nxt.mode = PM_ESC;
            end
            default: begin
              nb       = 2'd1;
              b0.glyph = b;
              if (x1 >= 16'(columns)) begin
                st_nxt.cursor_y = st.cursor_y + 16'd1;
                st_nxt.cursor_x = 16'd0;
              end else begin
                st_nxt.cursor_x = x1;
              end
            end
          endcase
        end
      end
    end

    set.res[0] = b0;
    set.res[1] = b1;
    cnt        = nb;

    // end of write: report the count after this byte, then clear write state
    if (!item.func && item.last_of_write) begin
      set.res[nb] = mk(OP_DONE, 8'd0, st_nxt.cursor_x, st_nxt.cursor_y,
                       st_nxt.fg, st_nxt.bg, st_nxt.hide, st_nxt.byte_count);
      cnt               = nb + 2'd1;
      st_nxt.byte_count = 16'd0;
      st_nxt.stopped    = 1'b0;
      st_nxt.mode       = PM_GROUND;
    end

    if (cnt != 2'd0) begin
      set.res[cnt - 2'd1].last = 1'b1;
    end
    set.cnt = cnt;
  end

endmodule

`default_nettype wire

### src/tcep_outq.sv
`default_nettype none

`include "assert_macros.svh"

module tcep_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_valid,
  input  tcep_pkg::res_set_t  load_set,
  output logic                load_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tcep_pkg::result_t   out_data
);
  import tcep_pkg::*;

  result_t [RES_MAX-1:0] buf_r;
  logic [RES_CNT_W-1:0]  rem_r;
  logic                  beat;

  assign out_valid  = (rem_r != 2'd0);
  assign out_data   = buf_r[0];
  assign beat       = out_valid && out_ready;
  // take a new set when empty or while the last pending beat leaves
  assign load_ready = (rem_r == 2'd0) || ((rem_r == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load_valid) begin
      rem_r <= load_set.cnt;
    end else if (beat) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid) begin
      buf_r <= load_set.res;
    end else if (beat) begin
      // advance the queue one beat
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
    end
  end

  `ASSERT_IMPLY(a_load_when_free, load_valid, load_ready, "result set loaded over pending beats")
  `ASSERT_IMPLY(a_last_on_final, rem_r == 2'd1, out_data.last, "final beat lacks last")
  `ASSERT_IMPLY(a_no_early_last, rem_r == 2'd2 || rem_r == 2'd3, !out_data.last,
                "last raised before final beat")

endmodule

`default_nettype wire

### src/text_console_escape_parser_unit.sv
// An accepted item sits in the input register until it fires: without waiting on the queue
// if it yields no results, else once the output queue can take them; its results then load
// the queue register, from which the first beat is offered.
// Throughput: one item per cycle when it yields at most one result and out_ready stays high;
// an item with more results holds the next one while the queue drains at most one beat a cycle.
// Reset (synchronous, rst_n low): columns 80, cursor 0,0, colors default 8,
// parser in ground, all arguments and counters cleared, both channels empty.
`default_nettype none

`include "assert_macros.svh"

module text_console_escape_parser_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tcep_pkg::item_t               in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tcep_pkg::result_t             out_data,
  input  logic                          cfg_we,
  input  logic [tcep_pkg::COLS_W-1:0]   cfg_data
);
  import tcep_pkg::*;

  logic [COLS_W-1:0] columns_r;
  item_t             inq_r;
  logic              inq_v_r;
  cons_state_t       st_r;
  cons_state_t       st_nxt;
  res_set_t          set;
  logic              q_ready;
  logic              fire;

  tcep_step u_step (
    .item    (inq_r),
    .st      (st_r),
    .columns (columns_r),
    .st_nxt  (st_nxt),
    .set     (set)
  );

  // an item with no results retires without waiting on the queue
  assign fire     = inq_v_r && ((set.cnt == 2'd0) || q_ready);
  assign in_ready = !inq_v_r || fire;

  tcep_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (fire && (set.cnt != 2'd0)),
    .load_set   (set),
    .load_ready (q_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r        <= COLUMNS_RST;
      inq_v_r          <= 1'b0;
      st_r.mode        <= PM_GROUND;
      st_r.args        <= '0;
      st_r.arg_idx     <= '0;
      st_r.cursor_x    <= '0;
      st_r.cursor_y    <= '0;
      st_r.fg          <= COLOR_DEFAULT;
      st_r.bg          <= COLOR_DEFAULT;
      st_r.hide        <= 1'b0;
      st_r.blink       <= 1'b0;
      st_r.stopped     <= 1'b0;
      st_r.byte_count  <= '0;
    end else begin
      if (cfg_we) begin
        columns_r <= cfg_data;
      end
      if (in_valid && in_ready) begin
        inq_v_r <= 1'b1;
      end else if (fire) begin
        inq_v_r <= 1'b0;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_r <= in_data;
    end
  end

  `ASSERT_NEXT(a_write_end_clears, fire && !inq_r.func && inq_r.last_of_write,
               st_r.byte_count == 16'd0 && !st_r.stopped, "write state not cleared")
  `ASSERT_IMPLY(a_stopped_ground, st_r.stopped, st_r.mode == PM_GROUND,
                "parser left ground while write stopped")

endmodule

`default_nettype wire

### tb/sv/text_console_escape_parser_unit_tb.sv
`timescale 1ns / 100ps

module text_console_escape_parser_unit_tb;
  import tcep_pkg::*;

  localparam int CLK_HIGH        = 6;
  localparam int CLK_LOW         = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 3000;
  localparam int MAX_REPORTS     = 10;
  localparam int PHASE_ITEMS     = 42;
  localparam int BURST_ITEMS     = 30;

  // final letters with no action of their own
  localparam logic [7:0] FIN_NOP_K   = 8'h4B;
  localparam logic [7:0] FIN_NOP_L   = 8'h4C;
  localparam logic [7:0] FIN_UNKNOWN = 8'h4F;
  localparam logic [7:0] CH_STAR     = 8'h2A;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  item_t             in_data  = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  result_t           out_data;
  logic              cfg_we   = 1'b0;
  logic [COLS_W-1:0] cfg_data = '0;

  // console state as the block should hold it
  logic [COLS_W-1:0] columns_m;
  parse_mode_t       mode_m;
  logic [ARG_W-1:0]  args_m [MAX_ARGS];
  int                arg_pos_m;
  logic [15:0]       cur_x;
  logic [15:0]       cur_y;
  logic [3:0]        fg_m;
  logic [3:0]        bg_m;
  logic              hide_m;
  logic              blink_m;
  logic              stopped_m;
  logic [15:0]       count_m;

  result_t step_results[$];
  result_t expected_results[$];
  int      useful_items = 0;
  int      mismatch_count = 0;
  int      quiet_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    hold_off_req = 1'b0;

  text_console_escape_parser_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #CLK_HIGH;
    clk = 1'b0;
    #CLK_LOW;
  end

  function automatic void reset_console_model();
    columns_m = COLUMNS_RST;
    mode_m    = PM_GROUND;
    foreach (args_m[i]) args_m[i] = '0;
    arg_pos_m = 0;
    cur_x     = '0;
    cur_y     = '0;
    fg_m      = COLOR_DEFAULT;
    bg_m      = COLOR_DEFAULT;
    hide_m    = 1'b0;
    blink_m   = 1'b0;
    stopped_m = 1'b0;
    count_m   = '0;
  endfunction

  function automatic void emit_result(op_t op, logic [7:0] glyph, logic [15:0] bytes);
    result_t r;
    r.op            = op;
    r.glyph         = glyph;
    r.col           = cur_x;
    r.row           = cur_y;
    r.fg_code       = fg_m;
    r.bg_code       = bg_m;
    r.cursor_hidden = hide_m;
    r.bytes_done    = bytes;
    r.last          = 1'b0;
    if (step_results.size() < RES_MAX) step_results.push_back(r);
  endfunction

  function automatic void draw_plain_byte(logic [7:0] b);
    if (b == CH_NL) begin
      emit_result(OP_DRAW, CH_SPACE, '0);
      cur_y = cur_y + 16'd1;
      cur_x = '0;
    end else if (b == CH_BS) begin
      emit_result(OP_DRAW, CH_SPACE, '0);
      if (cur_x == '0) begin
        cur_x = 16'(columns_m) - 16'd1;
        cur_y = cur_y - 16'd1;
      end else begin
        cur_x = cur_x - 16'd1;
      end
      emit_result(OP_DRAW, CH_SPACE, '0);
    end else if (b == CH_ESC) begin
      mode_m = PM_ESC;
    end else begin
      emit_result(OP_DRAW, b, '0);
      cur_x = cur_x + 16'd1;
      if (cur_x >= 16'(columns_m)) begin
        cur_y = cur_y + 16'd1;
        cur_x = '0;
      end
    end
  endfunction

  function automatic void run_final_letter(logic [7:0] b);
    logic [15:0] a0;
    logic [15:0] a1;
    a0 = args_m[0];
    a1 = args_m[1];
    case (b)
      FIN_UP:      cur_y = cur_y - a0;
      FIN_DOWN:    cur_y = cur_y + a0;
      FIN_LEFT:    cur_x = cur_x - a0;
      FIN_RIGHT:   cur_x = cur_x + a0;
      FIN_COL:     cur_x = a0;
      FIN_ROW:     cur_y = a0;
      FIN_HIDE:    hide_m = (a0 == '0);
      FIN_HOME: begin
        cur_x = a0;
        cur_y = a1;
      end
      FIN_CLEAR_I,
      FIN_CLEAR_J: emit_result(OP_CLEAR, '0, '0);
      FIN_FG:      if (a0 <= 16'd8) fg_m = a0[3:0];
      FIN_BG:      if (a0 <= 16'd8) bg_m = a0[3:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_console_item(item_t it);
    logic [7:0]  b;
    logic [31:0] acc;
    result_t     r;
    b = it.char_byte;
    step_results.delete();
    if (it.func || !stopped_m || it.last_of_write) useful_items++;
    if (it.func) begin
      blink_m = ~blink_m;
      emit_result(OP_DRAW, blink_m ? GLYPH_BLINK : CH_SPACE, '0);
    end else begin
      if (!stopped_m) begin
        if (b == CH_NUL) begin
          stopped_m = 1'b1;
          mode_m    = PM_GROUND;
        end else begin
          if (count_m != 16'hFFFF) count_m = count_m + 16'd1;
          case (mode_m)
            PM_ESC: begin
              if (b == CH_LBRACKET) begin
                mode_m = PM_ARGS;
                foreach (args_m[i]) args_m[i] = '0;
                arg_pos_m = 0;
              end else begin
                mode_m = PM_GROUND;
                draw_plain_byte(b);
              end
            end
            PM_ARGS: begin
              if (b >= CH_DIGIT0 && b <= CH_DIGIT9) begin
                acc = args_m[arg_pos_m] * 32'd10 + 32'(b - CH_DIGIT0);
                args_m[arg_pos_m] = (acc > 32'hFFFF) ? 16'hFFFF : acc[15:0];
              end else if (b == CH_SEMI) begin
                // a separator at the last slot is dropped
                if (arg_pos_m < MAX_ARGS - 1) arg_pos_m++;
              end else begin
                mode_m = PM_GROUND;
                run_final_letter(b);
              end
            end
            default: draw_plain_byte(b);
          endcase
        end
      end
      if (it.last_of_write) begin
        emit_result(OP_DONE, '0, count_m);
        count_m   = '0;
        stopped_m = 1'b0;
        mode_m    = PM_GROUND;
      end
    end
    foreach (step_results[i]) begin
      r      = step_results[i];
      r.last = (i == step_results.size() - 1);
      expected_results.push_back(r);
    end
  endfunction

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: expected op %0d glyph %0h col %0d row %0d fg %0d bg %0d hide %0d",
               $time, what, want.op, want.glyph, want.col, want.row, want.fg_code,
               want.bg_code, want.cursor_hidden,
               " done %0d last %0d / got op %0d glyph %0h col %0d row %0d fg %0d bg %0d",
               want.bytes_done, want.last, got.op, got.glyph, got.col, got.row,
               got.fg_code, got.bg_code,
               " hide %0d done %0d last %0d", got.cursor_hidden, got.bytes_done, got.last);
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with none expected", '0, out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.op !== want.op || out_data.glyph !== want.glyph ||
            out_data.col !== want.col || out_data.row !== want.row ||
            out_data.fg_code !== want.fg_code || out_data.bg_code !== want.bg_code ||
            out_data.cursor_hidden !== want.cursor_hidden ||
            out_data.bytes_done !== want.bytes_done || out_data.last !== want.last)
          note_mismatch("result mismatch", want, out_data);
      end
    end
  end

  // stop when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(logic func, logic [7:0] char_byte, logic last_of_write);
    item_t it;
    it.func          = func;
    it.char_byte     = char_byte;
    it.last_of_write = last_of_write;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_console_item(it);
  endtask

  task automatic send_byte(logic [7:0] b, logic last = 1'b0);
    send_item(1'b0, b, last);
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // a negative entry stands for an empty argument
  task automatic send_csi(int args[$], logic [7:0] fin, logic last = 1'b0);
    string digits;
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    foreach (args[i]) begin
      if (i > 0) send_byte(CH_SEMI);
      if (args[i] >= 0) begin
        digits = $sformatf("%0d", args[i]);
        for (int j = 0; j < digits.len(); j++) send_byte(digits[j]);
      end
    end
    send_byte(fin, last);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_columns(logic [COLS_W-1:0] value);
    wait_idle();
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    columns_m = value;
  endtask

  function automatic logic random_last();
    return ($urandom_range(99) < 8);
  endfunction

  task automatic send_random_unit();
    int         pick;
    int         nargs;
    int         args[$];
    logic [7:0] fin;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_byte(8'($urandom_range(255, 1)), random_last());
    end else if (pick < 40) begin
      send_byte($urandom_range(1) ? CH_NL : CH_BS, random_last());
    end else if (pick < 50) begin
      send_tick();
    end else if (pick < 54) begin
      send_byte(CH_NUL, random_last());
    end else begin
      nargs = ($urandom_range(9) == 0) ? $urandom_range(12, 4) : $urandom_range(3, 1);
      for (int i = 0; i < nargs; i++) begin
        case ($urandom_range(9))
          0:       args.push_back(-1);
          1:       args.push_back($urandom_range(99999));
          default: args.push_back($urandom_range(99));
        endcase
      end
      // mostly real letters, now and then any byte to break the sequence
      if ($urandom_range(19) == 0)
        fin = 8'($urandom_range(255));
      else
        fin = FIN_UP + 8'($urandom_range(14));
      send_csi(args, fin, random_last());
    end
  endtask

  task automatic test_plain_bytes();
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(CH_NL);
    send_byte(CH_BS);
    send_tick();
    send_tick();
    send_byte(CH_ESC);
    send_byte(8'h7E);
    send_byte(CH_BS, 1'b1);
    send_byte(CH_STAR);
    send_byte(CH_NUL);
    send_byte(8'h55);
    send_byte(8'h80, 1'b1);
    send_byte(CH_NUL, 1'b1);
  endtask

  task automatic test_escape_sequences();
    send_csi('{70000}, FIN_RIGHT);
    send_csi('{3}, FIN_UP);
    send_csi('{-1, 7}, FIN_HOME);
    send_byte(CH_STAR);
    send_csi('{12}, FIN_COL);
    send_csi('{4}, FIN_LEFT);
    send_csi('{2}, FIN_DOWN);
    send_csi('{5}, FIN_ROW);
    send_csi('{0}, FIN_HIDE);
    send_csi('{3}, FIN_FG);
    send_csi('{9}, FIN_BG);
    send_byte(CH_STAR);
    send_csi('{0}, FIN_BG);
    send_csi('{-1}, FIN_CLEAR_I);
    send_csi('{1, 2, 3, 4, 5, 6, 7, 8, 9, 10}, FIN_CLEAR_J);
    send_csi('{1}, FIN_HIDE);
    send_csi('{4}, FIN_NOP_K);
    send_csi('{4}, FIN_NOP_L);
    send_csi('{4}, FIN_UNKNOWN, 1'b1);
    // write ends inside a sequence, then ESC alone at the end of a write
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    send_byte(CH_DIGIT0 + 8'd4, 1'b1);
    send_byte(FIN_RIGHT);
    send_byte(CH_ESC, 1'b1);
    send_byte(CH_LBRACKET);
  endtask

  task automatic test_column_wrap();
    set_columns(13'd3);
    send_byte(CH_NL);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
    send_byte(CH_BS);
    set_columns(13'd0);
    send_byte(8'h78);
    send_byte(CH_BS);
    set_columns(13'd4096);
    send_csi('{4094}, FIN_COL);
    send_byte(8'h79);
    send_byte(8'h7A);
    set_columns(13'd1);
    send_byte(8'h70);
    send_byte(CH_BS, 1'b1);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, logic [COLS_W-1:0] cols);
    int target;
    set_columns(cols);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = useful_items + PHASE_ITEMS;
    while (useful_items < target) send_random_unit();
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    set_columns(13'd40);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b1;
    // keep offering while results pile up behind the stalled output
    for (int i = 0; i < BURST_ITEMS; i++)
      send_byte((i % 7 == 6) ? CH_BS : 8'($urandom_range(126, 33)), 1'(i == BURST_ITEMS - 1));
    wait_idle();
  endtask

  initial begin
    reset_console_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_bytes();
    test_escape_sequences();
    test_column_wrap();
    test_random_traffic(0, 0, 13'd80);
    test_random_traffic(79, 0, 13'd1);
    test_random_traffic(0, 79, 13'd4096);
    test_random_traffic(11, 11, 13'($urandom_range(200, 2)));
    test_output_backpressure();

    wait_idle();
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
